FILE: sv/kst_pkg.sv
// Shared types and constants for the key slot table with a LIFO free list.
// No dependencies; imported by every module of the block.
`default_nettype none

package kst_pkg;

    // Operation codes
    typedef enum logic [1:0] {
        FN_CREATE = 2'd0,
        FN_DELETE = 2'd1,
        FN_SET    = 2'd2,
        FN_GET    = 2'd3
    } t_func;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Free list head value that marks an empty list
    localparam logic [31:0] FREE_EMPTY = 32'hFFFF_FFFF;

    typedef struct packed {
        t_func              func;
        logic signed [7:0]  key;
        logic [31:0]        value;
        logic [31:0]        cleanup_handle;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  key_out;
        logic [31:0] value_out;
        logic        run_cleanup;
        logic [31:0] cleanup_out;
    } t_rsp;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture request, issue slot read
        logic exec;   // update slot and free list, register result
    } t_dp_cmd;

endpackage

`default_nettype wire

FILE: sv/kst_ctrl.sv
// Controller for the key slot table: two-state sequencer and result strobe.
// Depends on kst_pkg.
`default_nettype none

module kst_ctrl
    import kst_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    output logic         o_done,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    // Decode commands
    assign busy       = (r_state == S_EXEC);
    assign o_cmd.load = start && !busy;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign n_done     = o_cmd.exec;
    assign o_done     = r_done;

    // Advance state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (o_cmd.load) n_state = S_EXEC;
            S_EXEC: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted transfer did not enter execution");

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result strobe without a preceding execute cycle");

endmodule

`default_nettype wire

FILE: sv/kst_dp.sv
// Datapath for the key slot table: slot value and link memories, free list
// head, allocation count and the result register. Depends on kst_pkg.
`default_nettype none

module kst_dp
    import kst_pkg::*;
#(
    parameter int MAX_KEYS = 64
)(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_cmd i_cmd,
    input  wire t_req    i_req,
    output t_rsp         o_rsp
);

    localparam int KW = $clog2(MAX_KEYS);
    localparam int UW = $clog2(MAX_KEYS + 1);
    localparam int CW = KW + 8;

    // Slot storage
    logic [31:0] mem_value [MAX_KEYS];
    logic [31:0] mem_link  [MAX_KEYS];

    logic [31:0]   r_free_head, n_free_head;
    logic [UW-1:0] r_used, n_used;

    t_func         r_func;
    logic          r_key_ok, r_from_free, r_full;
    logic [KW-1:0] r_idx;
    logic [31:0]   r_value, r_hnd;
    logic [31:0]   r_rd_value, r_rd_link;
    t_rsp          r_rsp;

    logic [CW-1:0] key_ext;
    logic          key_ok, have_free, is_full;
    logic [KW-1:0] rd_addr;
    logic [KW+5:0] idx_ext;

    logic          we_value, we_link;
    logic [31:0]   wr_value, wr_link;
    t_rsp          rsp;

    // Decode the request at accept time
    assign key_ext   = CW'($unsigned(i_req.key));
    assign key_ok    = !i_req.key[7] && (key_ext < CW'(r_used));
    assign have_free = !r_free_head[31] && (r_free_head < 32'(r_used));
    assign is_full   = (r_used == UW'(MAX_KEYS));

    always_comb begin
        if (i_req.func == FN_CREATE)
            rd_addr = have_free ? r_free_head[KW-1:0] : r_used[KW-1:0];
        else
            rd_addr = key_ext[KW-1:0];
    end

    // Capture request and read the slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= i_req.func;
            r_key_ok    <= key_ok;
            r_from_free <= have_free;
            r_full      <= is_full;
            r_idx       <= rd_addr;
            r_value     <= i_req.value;
            r_hnd       <= i_req.cleanup_handle;
            r_rd_value  <= mem_value[rd_addr];
            r_rd_link   <= mem_link[rd_addr];
        end
    end

    assign idx_ext = (KW + 6)'(r_idx);

    // Execute the operation on the slot that was read
    always_comb begin
        n_free_head = r_free_head;
        n_used      = r_used;
        we_value    = 1'b0;
        we_link     = 1'b0;
        wr_value    = '0;
        wr_link     = '0;
        rsp         = '0;
        rsp.status  = ST_OK;
        if (r_func == FN_CREATE) begin
            if (r_from_free)
                n_free_head = r_rd_link;
            else if (!r_free_head[31])
                n_free_head = FREE_EMPTY;   // broken link: drop the list
            if (r_from_free || !r_full) begin
                if (!r_from_free)
                    n_used = r_used + UW'(1);
                we_value    = 1'b1;
                we_link     = 1'b1;
                wr_link     = r_hnd;
                rsp.key_out = idx_ext[5:0];
            end else begin
                rsp.status = ST_FULL;
            end
        end else if (!r_key_ok) begin
            rsp.status = ST_RANGE;
        end else begin
            unique case (r_func)
                FN_DELETE: begin
                    if (r_rd_link != '0 && r_rd_value != '0) begin
                        rsp.run_cleanup = 1'b1;
                        rsp.cleanup_out = r_rd_link;
                        rsp.value_out   = r_rd_value;
                    end
                    we_value    = 1'b1;
                    we_link     = 1'b1;
                    wr_link     = r_free_head;
                    n_free_head = 32'(r_idx);
                end
                FN_SET: begin
                    we_value = 1'b1;
                    wr_value = r_value;
                end
                FN_GET:    rsp.value_out = r_rd_value;
                FN_CREATE: ;
                default:   ;
            endcase
        end
    end

    // Write back slot and register the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (we_value) mem_value[r_idx] <= wr_value;
            if (we_link)  mem_link[r_idx]  <= wr_link;
            r_rsp <= rsp;
        end
    end

    // Hold free list head and allocation count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= FREE_EMPTY;
            r_used      <= '0;
        end else if (i_cmd.exec) begin
            r_free_head <= n_free_head;
            r_used      <= n_used;
        end
    end

    assign o_rsp = r_rsp;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(MAX_KEYS))
        else $error("allocation count beyond table size");

    a_exec_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> $past(i_cmd.load))
        else $error("execute without a captured request");

    a_fresh_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_func == FN_CREATE && !r_from_free && !r_full)
            |=> (r_used == $past(r_used) + UW'(1)))
        else $error("fresh slot allocation did not advance the count");

endmodule

`default_nettype wire

FILE: sv/key_slot_table_free_list_top.sv
// Top level of the key slot table with a LIFO free list.
// Depends on kst_pkg, kst_ctrl and kst_dp.
//
// Usage:
//   Drive a request on i_req and raise start; the request transfers at the
//   rising edge where start is high and busy is low. Operations: create
//   (allocate a slot, store the cleanup handle, return the key), delete
//   (report cleanup, push the slot on the free list), set and get value.
//   The result appears on o_rsp, marked by o_done for exactly one cycle; the
//   receiver must take it then, as there is no way to hold it off.
// Timing:
//   The accept edge reads the slot memories (one registered read port each),
//   the next edge writes the slot back and registers the result. o_done is
//   high in the cycle after that, during which busy is already low, so a new
//   request may transfer then. No new request is taken while one executes.
// Reset:
//   i_rst_n is synchronous and active low. It empties the free list and
//   clears the allocation count; slot memories are not cleared and hold no
//   meaning until a create writes them.
`default_nettype none

module key_slot_table_free_list_top
    import kst_pkg::*;
#(
    parameter int MAX_KEYS = 64
)(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_done,
    output t_rsp      o_rsp
);

    t_dp_cmd cmd;

    kst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    kst_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
